// File: rtl/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types, codes and delay-line helpers for the Hogge phase detector.
// ----------------------------------------------------------------------------
package hpd_pkg;

	localparam int DELAY_W = 16;
	localparam int COUNT_W = DELAY_W + 1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = DELAY_W;

	localparam logic [CFG_INDEX_W-1:0] REG_FLOP_DELAY = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_XOR_DELAY = 1'b1;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1;

	localparam logic [1:0] PUMP_DOWN = 2'd0;
	localparam logic [1:0] PUMP_UP = 2'd1;
	localparam logic [1:0] PUMP_NONE = 2'd2;

	// one delayed flop or inertial gate
	typedef struct packed {
		logic val;
		logic busy;
		logic [COUNT_W-1:0] count;
		logic out;
	} line_t;

	function automatic line_t line_tick(input line_t d);
		line_t r;
		r = d;
		if (d.busy && (d.count != COUNT_MAX)) begin
			r.count = d.count + COUNT_W'(1);
		end
		return r;
	endfunction

	function automatic line_t line_start(input line_t d, input logic v);
		line_t r;
		r = d;
		r.val = v;
		r.busy = 1'b1;
		r.count = '0;
		return r;
	endfunction

	function automatic line_t line_fire(input line_t d, input logic [DELAY_W-1:0] delay);
		line_t r;
		r = d;
		if (d.busy && (d.count > {1'b0, delay})) begin
			r.out = d.val;
			r.busy = 1'b0;
		end
		return r;
	endfunction

	function automatic line_t gate_offer(input line_t d, input logic v);
		line_t r;
		r = d;
		if (!d.busy && (v != d.val)) begin
			r = line_start(d, v);
		end
		return r;
	endfunction

endpackage

// File: rtl/hogge_phase_detector_delayed.sv
// ----------------------------------------------------------------------------
// hogge_phase_detector_delayed
// Hogge phase detector with delayed capture flops and inertial XOR gates.
// ----------------------------------------------------------------------------
// Each item is one tick of clock and data; each item yields one pump_state
// item. The block takes one item per cycle when out_ready does not stall
// the result register; an accepted item is held in the input register, and
// the state update is combinational between it and the result register.
// The state update for a tick depends on the previous tick's state, which
// is set by that single update stage. The delay registers are to be written
// through the cfg port only while idle; the block does not enforce this.
module hogge_phase_detector_delayed import hpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   clock_level,
	input  logic                   data_level,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             pump_state
);

	logic [DELAY_W-1:0] flop_delay_q, xor_delay_q;
	logic               valid_s1, clock_s1, data_s1;
	logic               advance;
	logic [1:0]         pump_next;

	assign advance = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flop_delay_q <= DELAY_RESET;
			xor_delay_q <= DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLOP_DELAY: flop_delay_q <= cfg_data;
				REG_XOR_DELAY: xor_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			clock_s1 <= clock_level;
			data_s1 <= data_level;
		end
	end

	hpd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.clock_bit  (clock_s1),
		.data_bit   (data_s1),
		.flop_delay (flop_delay_q),
		.xor_delay  (xor_delay_q),
		.pump_next  (pump_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pump_state <= pump_next;
		end
	end

`ifndef SYNTHESIS
	a_pump_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pump_state == PUMP_DOWN || pump_state == PUMP_UP ||
			pump_state == PUMP_NONE))
		else $error("pump_state holds an unused code");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(clock_s1) && $stable(data_s1))
		else $error("stalled input register lost its item");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_move_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid)
		else $error("processed item did not reach the result register");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_FLOP_DELAY |=> flop_delay_q == $past(cfg_data))
		else $error("flop delay write not taken");
`endif

endmodule

// File: rtl/hpd_core.sv
// ----------------------------------------------------------------------------
// hpd_core
// Detector state and the per-tick update: flop captures, flop delays,
// inertial XOR gates and pump decode.
// ----------------------------------------------------------------------------
module hpd_core import hpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               clock_bit,
	input  logic               data_bit,
	input  logic [DELAY_W-1:0] flop_delay,
	input  logic [DELAY_W-1:0] xor_delay,
	output logic [1:0]         pump_next
);

	logic  prev_clock_q;
	line_t first_q, second_q, gate_a_q, gate_b_q;
	line_t first_d, second_d, gate_a_d, gate_b_d;

	always_comb begin
		first_d = line_tick(first_q);
		second_d = line_tick(second_q);
		gate_a_d = line_tick(gate_a_q);
		gate_b_d = line_tick(gate_b_q);

		if (clock_bit && !prev_clock_q) begin
			first_d = line_start(first_d, data_bit);
		end else if (!clock_bit && prev_clock_q) begin
			second_d = line_start(second_d, first_d.out);
		end

		first_d = line_fire(first_d, flop_delay);
		second_d = line_fire(second_d, flop_delay);

		gate_a_d = gate_offer(gate_a_d, first_d.out ^ data_bit);
		gate_b_d = gate_offer(gate_b_d, first_d.out ^ second_d.out);

		gate_a_d = line_fire(gate_a_d, xor_delay);
		gate_b_d = line_fire(gate_b_d, xor_delay);

		if (gate_a_d.out && !gate_b_d.out) begin
			pump_next = PUMP_UP;
		end else if (!gate_a_d.out && gate_b_d.out) begin
			pump_next = PUMP_DOWN;
		end else begin
			pump_next = PUMP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clock_q <= 1'b0;
			first_q <= '0;
			second_q <= '0;
			gate_a_q <= '0;
			gate_b_q <= '0;
		end else if (step) begin
			prev_clock_q <= clock_bit;
			first_q <= first_d;
			second_q <= second_d;
			gate_a_q <= gate_a_d;
			gate_b_q <= gate_b_d;
		end
	end

endmodule
